// ===== hw/rtl/sensor_packet_framer_crc16_defines.svh =====
// sensor_packet_framer_crc16_defines.svh
// Assertion macros shared by the framer RTL; no dependencies.
`ifndef SENSOR_PACKET_FRAMER_CRC16_DEFINES_SVH
`define SENSOR_PACKET_FRAMER_CRC16_DEFINES_SVH

// condition a implies condition c in the same cycle
`define SPF_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("%m: check failed");

// condition a implies condition c in the next cycle
`define SPF_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("%m: check failed");

`endif

// ===== hw/rtl/spf_pkg.sv =====
// spf_pkg.sv
// Types, frame constants and the CRC-16/MODBUS byte update for the framer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

   // frame marker bytes and crc constants
   localparam logic [7:0]  MARK_START  = 8'h55;
   localparam logic [7:0]  MARK_HEADER = 8'hAA;
   localparam logic [7:0]  MARK_END    = 8'h33;
   localparam logic [7:0]  PAD_BYTE    = 8'h00;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;

   // byte positions within one frame
   typedef logic [3:0] frame_idx_type;
   localparam frame_idx_type IDX_START  = 4'd0;
   localparam frame_idx_type IDX_HEADER = 4'd1;
   localparam frame_idx_type IDX_PPM_LO = 4'd2;
   localparam frame_idx_type IDX_PPM_HI = 4'd3;
   localparam frame_idx_type IDX_FLAGS  = 4'd4;
   localparam frame_idx_type IDX_SEQ    = 4'd5;
   localparam frame_idx_type IDX_PAD    = 4'd6;
   localparam frame_idx_type IDX_CRC_LO = 4'd7;
   localparam frame_idx_type IDX_CRC_HI = 4'd8;
   localparam frame_idx_type IDX_END    = 4'd9;

   // one classified measurement waiting for serialisation
   typedef struct packed {
      logic [15:0] ppm;
      logic [7:0]  flags;
      logic [7:0]  seq;
   } frame_fields_type;

   // reflected crc-16 update over one byte, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spf_front.sv =====
// spf_front.sv
// Request side: takes measurements, builds the flags byte and stamps the sequence count.
// Depends on spf_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_packet_framer_crc16_defines.svh"

module spf_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [23:0]               req_tdata,
   input  wire logic                      q_full,
   output logic                           q_push,
   output spf_pkg::frame_fields_type      q_wdata
);

   logic [7:0] seq_ff;
   logic [7:0] seq_in;

   // accept whenever the queue has room
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   // classify the request into frame fields
   always_comb begin
      q_wdata.ppm   = req_tdata[15:0];
      q_wdata.flags = {4'b0000, req_tdata[19], req_tdata[18], req_tdata[17:16]};
      q_wdata.seq   = seq_ff;
   end

   // sequence count, wraps naturally at 255
   assign seq_in = q_push ? seq_ff + 8'd1 : seq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 8'd0;
      end else begin
         seq_ff <= seq_in;
      end
   end

   `SPF_ASSERT_NEXT(a_seq_step, clock, reset, q_push, seq_ff == $past(seq_ff) + 8'd1)
   `SPF_ASSERT_NEXT(a_seq_hold, clock, reset, !q_push, seq_ff == $past(seq_ff))

endmodule

`default_nettype wire

// ===== hw/rtl/spf_queue.sv =====
// spf_queue.sv
// Short register queue between the request side and the frame serialiser.
// Depends on spf_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_packet_framer_crc16_defines.svh"

module spf_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire spf_pkg::frame_fields_type wdata,
   output logic                           full,
   input  wire logic                      pop,
   output logic                           not_empty,
   output spf_pkg::frame_fields_type      rdata
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

   spf_pkg::frame_fields_type entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full      = (count_ff == DepthCnt);
   assign not_empty = (count_ff != '0);
   assign rdata     = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, payload only
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   `SPF_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= DepthCnt)
   `SPF_ASSERT_IMP(a_no_lost_push, clock, reset, push, !full)

endmodule

`default_nettype wire

// ===== hw/rtl/spf_back.sv =====
// spf_back.sv
// Frame serialiser: emits ten bytes per measurement and folds bytes 1 to 6 into the crc.
// Depends on spf_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_packet_framer_crc16_defines.svh"

module spf_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_not_empty,
   input  wire spf_pkg::frame_fields_type q_rdata,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast
);

   spf_pkg::frame_idx_type idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        valid_ff, valid_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic        load;
   logic        at_end;

   // output register is free when empty or being taken
   assign load   = q_not_empty && (!valid_ff || rsp_tready);
   assign at_end = (idx_ff == spf_pkg::IDX_END);
   assign q_pop  = load && at_end;

   // byte selection for the current position
   always_comb begin
      unique case (idx_ff)
         spf_pkg::IDX_START:  data_in = spf_pkg::MARK_START;
         spf_pkg::IDX_HEADER: data_in = spf_pkg::MARK_HEADER;
         spf_pkg::IDX_PPM_LO: data_in = q_rdata.ppm[7:0];
         spf_pkg::IDX_PPM_HI: data_in = q_rdata.ppm[15:8];
         spf_pkg::IDX_FLAGS:  data_in = q_rdata.flags;
         spf_pkg::IDX_SEQ:    data_in = q_rdata.seq;
         spf_pkg::IDX_PAD:    data_in = spf_pkg::PAD_BYTE;
         spf_pkg::IDX_CRC_LO: data_in = crc_ff[7:0];
         spf_pkg::IDX_CRC_HI: data_in = crc_ff[15:8];
         default:             data_in = spf_pkg::MARK_END;
      endcase
   end

   // position, crc and output valid next values
   always_comb begin
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = at_end;
         idx_in   = at_end ? spf_pkg::IDX_START : idx_ff + 4'd1;
         if (idx_ff == spf_pkg::IDX_START) begin
            crc_in = spf_pkg::CRC_INIT;
         end else if (idx_ff <= spf_pkg::IDX_PAD) begin
            crc_in = spf_pkg::crc_byte(crc_ff, data_in);
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= spf_pkg::IDX_START;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   `SPF_ASSERT_IMP(a_idx_range, clock, reset, 1'b1, idx_ff <= spf_pkg::IDX_END)
   `SPF_ASSERT_NEXT(a_pop_last, clock, reset, q_pop, valid_ff && last_ff)
   `SPF_ASSERT_IMP(a_last_at_start, clock, reset, last_ff, idx_ff == spf_pkg::IDX_START)

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_packet_framer_crc16.sv =====
// Gas sensor packet framer. Each accepted request carries one measurement and
// produces a 10-byte frame on the response channel: 0x55, 0xAA, ppm low, ppm
// high, flags, sequence, 0x00, crc low, crc high, 0x33, with tlast on the
// final byte. The crc is CRC-16/MODBUS over bytes 1 to 6, computed as the
// frame goes out, one byte per cycle from the output register while the
// response channel does not stall; a new measurement starts only after the
// last byte of a frame. Up to QUEUE_DEPTH measurements are queued,
// including the one being sent, which is popped with its last byte, so with
// QUEUE_DEPTH above 1 requests are taken while a frame is still being sent.
// The sequence byte starts at 0 after reset and wraps from 255 to 0.
//
// sensor_packet_framer_crc16.sv
// Top level: connects request side, queue and frame serialiser; depends on spf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sensor_packet_framer_crc16 #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] ppm reading, [17:16] alarm level, [18] system on, [19] relay on, [23:20] zero
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] frame_byte
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   spf_pkg::frame_fields_type q_wdata;
   spf_pkg::frame_fields_type q_rdata;
   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_not_empty;

   // request side
   spf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   // measurement queue
   spf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .rdata     (q_rdata)
   );

   // frame serialiser
   spf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rdata     (q_rdata),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire
